// ===== hdl/point_triangle_barycentric_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the point/triangle barycentric block
// Shared wrappers so every check is written the same way.
// ---------------------------------------------------------------------------
`ifndef POINT_TRIANGLE_BARYCENTRIC_DEFINES_SVH
`define POINT_TRIANGLE_BARYCENTRIC_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define PTB_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptb: same-cycle check failed");

// Next-cycle implication, live through reset.
`define PTB_ASSERT_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ptb: next-cycle check failed");

`endif

// ===== hdl/ptb_pkg.sv =====
// ---------------------------------------------------------------------------
// ptb_pkg
// Constants and shared types for the point/triangle barycentric block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  // bits of the second operand taken per multiplier stage
  localparam int MUL_CHUNK = 16;
  // numerator scale: 2^24 for Q8.24 plus one bit for the half step
  localparam int DIV_SHIFT = 25;
  localparam int ONE_Q24 = 16777216;
  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;
  localparam longint OM_MAX = 64'sd2147483647;

  typedef struct packed {
    logic valid;
    logic degen;
  } ptb_ctl_t;

endpackage

// ===== hdl/ptb_mul.sv =====
// ---------------------------------------------------------------------------
// ptb_mul
// Pipelined signed multiplier; one chunk of the second operand per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_mul #(
  parameter int A_WIDTH = 33,
  parameter int B_WIDTH = 33
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [A_WIDTH-1:0]         a,
  input  logic signed [B_WIDTH-1:0]         b,
  output logic                              out_valid,
  output logic signed [A_WIDTH+B_WIDTH-1:0] p
);
  import ptb_pkg::*;

  localparam int NCH = (B_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BPW = NCH * MUL_CHUNK;
  localparam int PW  = A_WIDTH + B_WIDTH;

  logic [A_WIDTH-1:0] a_mag;
  logic [B_WIDTH-1:0] b_mag;
  logic [NCH:0]       vld;
  logic [A_WIDTH-1:0] am  [NCH+1];
  logic [BPW-1:0]     bm  [NCH+1];
  logic               neg [NCH+1];
  logic [PW-1:0]      acc [NCH+1];

  assign a_mag = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
  assign b_mag = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    am[0]  <= a_mag;
    bm[0]  <= BPW'(b_mag);
    neg[0] <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
    acc[0] <= '0;
  end

  for (genvar k = 1; k <= NCH; k++) begin : g_stage
    logic [A_WIDTH+MUL_CHUNK-1:0] pp;
    assign pp = am[k-1] * bm[k-1][(k-1)*MUL_CHUNK +: MUL_CHUNK];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      am[k]  <= am[k-1];
      bm[k]  <= bm[k-1];
      neg[k] <= neg[k-1];
      acc[k] <= acc[k-1] + (PW'(pp) << ((k-1) * MUL_CHUNK));
    end
  end

  // restore the sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[NCH];
    end
    p <= neg[NCH] ? -$signed(acc[NCH]) : $signed(acc[NCH]);
  end

endmodule

// ===== hdl/ptb_div.sv =====
// ---------------------------------------------------------------------------
// ptb_div
// Pipelined restoring divider: round(n * 2^24 / d), ties away from zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_div #(
  parameter int N_WIDTH = 141
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ptb_pkg::ptb_ctl_t                     ctl_in,
  input  logic signed [N_WIDTH-1:0]             n,
  input  logic signed [N_WIDTH-1:0]             d,
  output ptb_pkg::ptb_ctl_t                     ctl_out,
  output logic [N_WIDTH+ptb_pkg::DIV_SHIFT:0]   q_mag,
  output logic                                  q_neg
);
  import ptb_pkg::*;

  localparam int QW = N_WIDTH + DIV_SHIFT + 1;
  localparam int DW = N_WIDTH + 1;

  logic [N_WIDTH-1:0] n_mag;
  ptb_ctl_t           ctl [QW+1];
  logic [QW-1:0]      num [QW+1];
  logic [DW-1:0]      den [QW+1];
  logic [DW-1:0]      rem [QW+1];
  logic [QW-1:0]      q   [QW+1];
  logic               neg [QW+1];

  assign n_mag = n[N_WIDTH-1] ? N_WIDTH'(-n) : N_WIDTH'(n);

  // numerator |n| * 2^25 + d over divisor 2d
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0] <= ctl_in;
    end
    num[0] <= (QW'(n_mag) << DIV_SHIFT) + QW'(unsigned'(d));
    den[0] <= {unsigned'(d), 1'b0};
    rem[0] <= '0;
    q[0]   <= '0;
    neg[0] <= n[N_WIDTH-1];
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem[k-1], num[k-1][QW-1]};
    assign ge    = trial >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= ctl[k-1];
      end
      num[k] <= num[k-1] << 1;
      den[k] <= den[k-1];
      rem[k] <= ge ? DW'(trial - {1'b0, den[k-1]}) : DW'(trial);
      q[k]   <= {q[k-1][QW-2:0], ge};
      neg[k] <= neg[k-1];
    end
  end

  assign ctl_out = ctl[QW];
  assign q_mag   = q[QW];
  assign q_neg   = neg[QW];

endmodule

// ===== hdl/point_triangle_barycentric.sv =====
// ---------------------------------------------------------------------------
// point_triangle_barycentric
// Barycentric weights and outside measure of a point against a 3D triangle.
// ---------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  query in  | start, busy (always 0) | v0_*, v1_*, v2_*, point_* (Q16.16)
//  result out| done (one-cycle strobe)| weight_0..2, outside_measure, flags
//
//  One query is taken every cycle; busy never rises.
//  Pipe stages: 1 input stage, two multiplier pipelines (entry, chunk and
//  sign stages each, the chunks taken from the second operand), two add stages,
//  the divider (an entry stage plus one quotient bit per stage,
//  2*(2*(COORD_WIDTH+1)+2)+28 stages) and three output stages.
//  Synchronous reset clears every valid bit; payload registers are not reset.
//  Results leave on done and cannot be held off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_triangle_barycentric #(
  parameter int COORD_WIDTH = ptb_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] v0_x,
  input  logic [COORD_WIDTH-1:0] v0_y,
  input  logic [COORD_WIDTH-1:0] v0_z,
  input  logic [COORD_WIDTH-1:0] v1_x,
  input  logic [COORD_WIDTH-1:0] v1_y,
  input  logic [COORD_WIDTH-1:0] v1_z,
  input  logic [COORD_WIDTH-1:0] v2_x,
  input  logic [COORD_WIDTH-1:0] v2_y,
  input  logic [COORD_WIDTH-1:0] v2_z,
  input  logic [COORD_WIDTH-1:0] point_x,
  input  logic [COORD_WIDTH-1:0] point_y,
  input  logic [COORD_WIDTH-1:0] point_z,
  output logic                   done,
  output logic [31:0]            weight_0,
  output logic [31:0]            weight_1,
  output logic [31:0]            weight_2,
  output logic [30:0]            outside_measure,
  output logic                   degenerate,
  output logic                   saturated
);
  import ptb_pkg::*;

  // value widths along the pipe
  localparam int DW  = COORD_WIDTH + 1;      // edge and offset components
  localparam int P1W = 2 * DW;               // component products
  localparam int SW  = P1W + 2;              // dot products
  localparam int P2W = 2 * SW;               // products of dot products
  localparam int NW  = P2W + 1;              // determinant and numerators
  localparam int QW  = NW + DIV_SHIFT + 1;   // quotient magnitude
  localparam int WW  = QW + 1;               // signed weights 1 and 2
  localparam int W0W = QW + 3;               // signed weight 0
  localparam int OMW = QW + 4;               // outside measure before clip

  // the pipe never stalls, so the input side is always open
  assign busy = 1'b0;

  // ---- input stage: edges and offset from v0 ----
  logic signed [COORD_WIDTH-1:0] va [3];
  logic signed [COORD_WIDTH-1:0] vb [3];
  logic signed [COORD_WIDTH-1:0] vc [3];
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [DW-1:0]          e0 [3];
  logic signed [DW-1:0]          e1 [3];
  logic signed [DW-1:0]          dv [3];
  logic                          v_in;

  assign va[0] = v0_x;    assign va[1] = v0_y;    assign va[2] = v0_z;
  assign vb[0] = v1_x;    assign vb[1] = v1_y;    assign vb[2] = v1_z;
  assign vc[0] = v2_x;    assign vc[1] = v2_y;    assign vc[2] = v2_z;
  assign pt[0] = point_x; assign pt[1] = point_y; assign pt[2] = point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else begin
      v_in <= start & ~busy;
    end
    for (int k = 0; k < 3; k++) begin
      e0[k] <= DW'(vb[k]) - DW'(va[k]);
      e1[k] <= DW'(vc[k]) - DW'(va[k]);
      dv[k] <= DW'(pt[k]) - DW'(va[k]);
    end
  end

  // ---- component products for the five dot products ----
  logic signed [P1W-1:0] p00 [3];
  logic signed [P1W-1:0] p01 [3];
  logic signed [P1W-1:0] p11 [3];
  logic signed [P1W-1:0] pd0 [3];
  logic signed [P1W-1:0] pd1 [3];
  logic [2:0]            v_mul1;

  for (genvar k = 0; k < 3; k++) begin : g_mul1
    ptb_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_m00 (
      .clk(clk), .rst(rst), .in_valid(v_in), .a(e0[k]), .b(e0[k]),
      .out_valid(v_mul1[k]), .p(p00[k]));
    ptb_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_m01 (
      .clk(clk), .rst(rst), .in_valid(v_in), .a(e0[k]), .b(e1[k]),
      .out_valid(), .p(p01[k]));
    ptb_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_m11 (
      .clk(clk), .rst(rst), .in_valid(v_in), .a(e1[k]), .b(e1[k]),
      .out_valid(), .p(p11[k]));
    ptb_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_md0 (
      .clk(clk), .rst(rst), .in_valid(v_in), .a(dv[k]), .b(e0[k]),
      .out_valid(), .p(pd0[k]));
    ptb_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_md1 (
      .clk(clk), .rst(rst), .in_valid(v_in), .a(dv[k]), .b(e1[k]),
      .out_valid(), .p(pd1[k]));
  end

  // ---- dot products: sum the three components ----
  logic signed [SW-1:0] s00, s01, s11, dp0, dp1;
  logic                 v_dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dot <= 1'b0;
    end else begin
      v_dot <= &v_mul1;
    end
    s00 <= SW'(p00[0]) + SW'(p00[1]) + SW'(p00[2]);
    s01 <= SW'(p01[0]) + SW'(p01[1]) + SW'(p01[2]);
    s11 <= SW'(p11[0]) + SW'(p11[1]) + SW'(p11[2]);
    dp0 <= SW'(pd0[0]) + SW'(pd0[1]) + SW'(pd0[2]);
    dp1 <= SW'(pd1[0]) + SW'(pd1[1]) + SW'(pd1[2]);
  end

  // ---- Gram determinant and numerators, product terms ----
  logic signed [P2W-1:0] den_a, den_b, n1_a, n1_b, n2_a, n2_b;
  logic [5:0]            v_mul2;

  ptb_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_den_a (
    .clk(clk), .rst(rst), .in_valid(v_dot), .a(s00), .b(s11),
    .out_valid(v_mul2[0]), .p(den_a));
  ptb_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_den_b (
    .clk(clk), .rst(rst), .in_valid(v_dot), .a(s01), .b(s01),
    .out_valid(v_mul2[1]), .p(den_b));
  ptb_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_n1_a (
    .clk(clk), .rst(rst), .in_valid(v_dot), .a(dp0), .b(s11),
    .out_valid(v_mul2[2]), .p(n1_a));
  ptb_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_n1_b (
    .clk(clk), .rst(rst), .in_valid(v_dot), .a(s01), .b(dp1),
    .out_valid(v_mul2[3]), .p(n1_b));
  ptb_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_n2_a (
    .clk(clk), .rst(rst), .in_valid(v_dot), .a(s00), .b(dp1),
    .out_valid(v_mul2[4]), .p(n2_a));
  ptb_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_n2_b (
    .clk(clk), .rst(rst), .in_valid(v_dot), .a(s01), .b(dp0),
    .out_valid(v_mul2[5]), .p(n2_b));

  // ---- differences; the determinant is zero exactly when its terms match ----
  logic signed [NW-1:0] den, n1, n2;
  ptb_ctl_t             ctl_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_diff <= '0;
    end else begin
      ctl_diff.valid <= &v_mul2;
      ctl_diff.degen <= den_a == den_b;
    end
    den <= NW'(den_a) - NW'(den_b);
    n1  <= NW'(n1_a) - NW'(n1_b);
    n2  <= NW'(n2_a) - NW'(n2_b);
  end

  // ---- two rounding dividers side by side ----
  ptb_ctl_t      ctl_q;
  logic [QW-1:0] q1_mag, q2_mag;
  logic          q1_neg, q2_neg;

  ptb_div #(.N_WIDTH(NW)) u_div1 (
    .clk(clk), .rst(rst), .ctl_in(ctl_diff), .n(n1), .d(den),
    .ctl_out(ctl_q), .q_mag(q1_mag), .q_neg(q1_neg));
  ptb_div #(.N_WIDTH(NW)) u_div2 (
    .clk(clk), .rst(rst), .ctl_in(ctl_diff), .n(n2), .d(den),
    .ctl_out(), .q_mag(q2_mag), .q_neg(q2_neg));

  // ---- signed weights; weight 0 closes the sum to one ----
  logic signed [WW-1:0]  w1s, w2s;
  logic signed [W0W-1:0] w0r, w1r, w2r;
  ptb_ctl_t              ctl_w;

  assign w1s = q1_neg ? -$signed({1'b0, q1_mag}) : $signed({1'b0, q1_mag});
  assign w2s = q2_neg ? -$signed({1'b0, q2_mag}) : $signed({1'b0, q2_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_w <= '0;
    end else begin
      ctl_w <= ctl_q;
    end
    w1r <= W0W'(w1s);
    w2r <= W0W'(w2s);
    w0r <= W0W'(ONE_Q24) - W0W'(w1s) - W0W'(w2s);
  end

  // ---- outside measure and weight clipping ----
  logic signed [W0W-1:0] wv [3];
  logic [OMW-1:0]        om_sum;
  logic [31:0]           wclip [3];
  logic [2:0]            wsat;
  logic [31:0]           wout [3];
  logic [OMW-1:0]        om_r;
  logic                  wsat_r;
  ptb_ctl_t              ctl_x;

  assign wv[0] = w0r;
  assign wv[1] = w1r;
  assign wv[2] = w2r;

  always_comb begin
    om_sum = '0;
    for (int k = 0; k < 3; k++) begin
      // add the magnitude of each negative weight
      if (wv[k] < 0) begin
        om_sum = om_sum + OMW'(-wv[k]);
      end
      if (wv[k] > W0W'(OUT_MAX)) begin
        wclip[k] = 32'(OUT_MAX);
        wsat[k]  = 1'b1;
      end else if (wv[k] < W0W'(OUT_MIN)) begin
        wclip[k] = 32'(OUT_MIN);
        wsat[k]  = 1'b1;
      end else begin
        wclip[k] = 32'(wv[k]);
        wsat[k]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_x <= '0;
    end else begin
      ctl_x <= ctl_w;
    end
    for (int k = 0; k < 3; k++) begin
      wout[k] <= wclip[k];
    end
    om_r   <= om_sum << 1;
    wsat_r <= |wsat;
  end

  // ---- output register; a flat triangle drops every value to zero ----
  logic om_sat;

  assign om_sat = om_r > OMW'(OM_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_x.valid;
    end
    degenerate <= ctl_x.degen;
    if (ctl_x.degen) begin
      weight_0        <= '0;
      weight_1        <= '0;
      weight_2        <= '0;
      outside_measure <= '0;
      saturated       <= 1'b0;
    end else begin
      weight_0        <= wout[0];
      weight_1        <= wout[1];
      weight_2        <= wout[2];
      outside_measure <= om_sat ? 31'(OM_MAX) : 31'(om_r);
      saturated       <= wsat_r | om_sat;
    end
  end

endmodule

// ===== hdl/ptb_checker.sv =====
// ---------------------------------------------------------------------------
// ptb_props
// Port-level checks on the barycentric block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_triangle_barycentric_defines.svh"

module ptb_props (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [31:0] weight_0,
  input logic [31:0] weight_1,
  input logic [31:0] weight_2,
  input logic [30:0] outside_measure,
  input logic        degenerate,
  input logic        saturated
);
  import ptb_pkg::*;

  // no result straight out of reset
  `PTB_ASSERT_NEXT(a_quiet_after_reset, clk, rst, !done)

  // flat triangle: all values zero, no clipping
  `PTB_ASSERT_SAME(a_degen_zero, clk, rst, done && degenerate,
    (weight_0 == 32'd0) && (weight_1 == 32'd0) && (weight_2 == 32'd0) &&
    (outside_measure == 31'd0) && !saturated)

  // unclipped weights add up to one
  `PTB_ASSERT_SAME(a_partition, clk, rst, done && !degenerate && !saturated,
    32'(weight_0 + weight_1 + weight_2) == 32'(ONE_Q24))

  // outside measure is nonzero exactly when some weight is negative
  `PTB_ASSERT_SAME(a_outside, clk, rst, done && !degenerate,
    (outside_measure != 31'd0) == (weight_0[31] || weight_1[31] || weight_2[31]))

endmodule

bind point_triangle_barycentric ptb_props u_ptb_props (.*);

// ===== sim/ptb_checker.sv =====
// ---------------------------------------------------------------------------
// ptb_checker
// Watches the query and result channels of point_triangle_barycentric.
// It predicts each result and compares it with what comes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] v0_x,
  input  logic [31:0] v0_y,
  input  logic [31:0] v0_z,
  input  logic [31:0] v1_x,
  input  logic [31:0] v1_y,
  input  logic [31:0] v1_z,
  input  logic [31:0] v2_x,
  input  logic [31:0] v2_y,
  input  logic [31:0] v2_z,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  input  logic        done,
  input  logic [31:0] weight_0,
  input  logic [31:0] weight_1,
  input  logic [31:0] weight_2,
  input  logic [30:0] outside_measure,
  input  logic        degenerate,
  input  logic        saturated,
  output int          fail_count,
  output int          pending,
  output int          n_degen,
  output int          n_sat,
  output int          n_outside
);

  typedef logic signed [319:0] big_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [30:0] om;
    logic        degen;
    logic        sat;
  } bary_t;

  bary_t weights_q[$];

  // clip to [lo, hi] and note any clipping
  function automatic big_t clip_val(big_t v, big_t lo, big_t hi, ref bit sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // round(n * 2^24 / den), ties away from zero; den > 0
  function automatic big_t div_q24(big_t n, big_t den);
    big_t mag;
    big_t q;
    mag = (n < 0) ? -n : n;
    q = ((mag <<< ptb_pkg::DIV_SHIFT) + den) / (den <<< 1);
    return (n < 0) ? -q : q;
  endfunction

  function automatic big_t dot3(big_t a[3], big_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic bary_t predict_bary(logic [31:0] c[12]);
    big_t  e0[3], e1[3], dv[3];
    big_t  s00, s01, s11, p0, p1, den, w[3], om;
    bary_t r;
    bit    sat;
    sat = 1'b0;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      e0[k] = big_t'($signed(c[3 + k])) - big_t'($signed(c[k]));
      e1[k] = big_t'($signed(c[6 + k])) - big_t'($signed(c[k]));
      dv[k] = big_t'($signed(c[9 + k])) - big_t'($signed(c[k]));
    end
    s00 = dot3(e0, e0);
    s01 = dot3(e0, e1);
    s11 = dot3(e1, e1);
    p0  = dot3(dv, e0);
    p1  = dot3(dv, e1);
    den = s00 * s11 - s01 * s01;
    if (den == 0) begin
      r.degen = 1'b1;
      return r;
    end
    w[1] = div_q24(p0 * s11 - s01 * p1, den);
    w[2] = div_q24(s00 * p1 - s01 * p0, den);
    w[0] = big_t'(ptb_pkg::ONE_Q24) - w[1] - w[2];
    // outside measure from the unclipped weights
    om = 0;
    for (int k = 0; k < 3; k++) if (w[k] < 0) om = om - w[k];
    om = om <<< 1;
    r.w0 = 32'(clip_val(w[0], big_t'(ptb_pkg::OUT_MIN), big_t'(ptb_pkg::OUT_MAX), sat));
    r.w1 = 32'(clip_val(w[1], big_t'(ptb_pkg::OUT_MIN), big_t'(ptb_pkg::OUT_MAX), sat));
    r.w2 = 32'(clip_val(w[2], big_t'(ptb_pkg::OUT_MIN), big_t'(ptb_pkg::OUT_MAX), sat));
    r.om = 31'(clip_val(om, '0, big_t'(ptb_pkg::OM_MAX), sat));
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    logic [31:0] c[12];
    bary_t       want;
    bary_t       got;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
      n_degen    <= 0;
      n_sat      <= 0;
      n_outside  <= 0;
      weights_q.delete();
    end else begin
      if (start && !busy) begin
        c = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
              point_x, point_y, point_z};
        weights_q.push_back(predict_bary(c));
      end
      if (done) begin
        got = '{weight_0, weight_1, weight_2, outside_measure, degenerate, saturated};
        if (weights_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = weights_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch w0 exp %h act %h, w1 exp %h act %h, w2 exp %h act %h",
                     $time, want.w0, got.w0, want.w1, got.w1, want.w2, got.w2);
            $display("%0t:   outside exp %h act %h, degen exp %b act %b, sat exp %b act %b",
                     $time, want.om, got.om, want.degen, got.degen, want.sat, got.sat);
            fail_count <= fail_count + 1;
          end
          if (want.degen) n_degen <= n_degen + 1;
          if (want.sat) n_sat <= n_sat + 1;
          if (want.om != 0) n_outside <= n_outside + 1;
        end
      end
      pending <= weights_q.size();
    end
  end

endmodule

// ===== sim/tb_point_triangle_barycentric.sv =====
// ---------------------------------------------------------------------------
// tb_point_triangle_barycentric
// Stimulus and verdict for the point/triangle barycentric block.
// Directed triangles first, then random ones under three idling regimes;
// a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_triangle_barycentric;

  localparam int N_RANDOM    = 1340;
  localparam int DRAIN       = 600;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] crd[12];
  logic        done;
  logic [31:0] weight_0, weight_1, weight_2;
  logic [30:0] outside_measure;
  logic        degenerate, saturated;
  int          fail_count, pending, n_degen, n_sat, n_outside;
  int          cycles = 0;
  int          n_sent = 0;

  initial for (int k = 0; k < 12; k++) crd[k] = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  point_triangle_barycentric u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(crd[0]), .v0_y(crd[1]), .v0_z(crd[2]),
    .v1_x(crd[3]), .v1_y(crd[4]), .v1_z(crd[5]),
    .v2_x(crd[6]), .v2_y(crd[7]), .v2_z(crd[8]),
    .point_x(crd[9]), .point_y(crd[10]), .point_z(crd[11]),
    .done(done), .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2),
    .outside_measure(outside_measure), .degenerate(degenerate), .saturated(saturated)
  );

  ptb_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(crd[0]), .v0_y(crd[1]), .v0_z(crd[2]),
    .v1_x(crd[3]), .v1_y(crd[4]), .v1_z(crd[5]),
    .v2_x(crd[6]), .v2_y(crd[7]), .v2_z(crd[8]),
    .point_x(crd[9]), .point_y(crd[10]), .point_z(crd[11]),
    .done(done), .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2),
    .outside_measure(outside_measure), .degenerate(degenerate), .saturated(saturated),
    .fail_count(fail_count), .pending(pending), .n_degen(n_degen), .n_sat(n_sat),
    .n_outside(n_outside)
  );

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive one query at the falling edge and hold it until it is accepted;
  // start stays high so back-to-back queries need no gap.
  task automatic send_query(input logic [31:0] q[12]);
    @(negedge clk);
    for (int k = 0; k < 12; k++) crd[k] <= q[k];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Drop start for a run of idle cycles, each with the given chance.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Q16.16 helper: whole units to fixed point
  function automatic logic [31:0] fx(input int units);
    return 32'(units <<< 16);
  endfunction

  // small signed coordinate, about +/-8 units
  function automatic logic [31:0] small_crd();
    return 32'($signed(20'($urandom)));
  endfunction

  task automatic random_query(output logic [31:0] q[12]);
    int mode;
    int m;
    mode = $urandom_range(99);
    for (int k = 0; k < 12; k++) q[k] = small_crd();
    if (mode < 15) begin
      // full-range coordinates: overflow and saturation territory
      for (int k = 0; k < 12; k++) q[k] = $urandom;
    end else if (mode < 25) begin
      // third vertex on the line through the first two
      m = $urandom_range(3);
      for (int k = 0; k < 3; k++) q[6 + k] = q[k] + 32'(m) * (q[3 + k] - q[k]);
    end else if (mode < 30) begin
      // coincident first and second vertex
      for (int k = 0; k < 3; k++) q[3 + k] = q[k];
    end else if (mode < 40) begin
      // point on one of the vertices
      m = $urandom_range(2);
      for (int k = 0; k < 3; k++) q[9 + k] = q[3 * m + k];
    end else if (mode < 50) begin
      // tiny triangle, large quotients
      for (int k = 0; k < 3; k++) begin
        q[3 + k] = q[k] + 32'($signed(3'($urandom)));
        q[6 + k] = q[k] + 32'($signed(3'($urandom)));
      end
    end
  endtask

  initial begin
    logic [31:0] q[12];
    int          pct;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unit right triangle in the xy plane with assorted points.
    q = '{fx(0), fx(0), fx(0), fx(1), fx(0), fx(0), fx(0), fx(1), fx(0),
          32'h0000_4000, 32'h0000_4000, fx(0)};
    send_query(q);
    q[9] = fx(0); q[10] = fx(0); send_query(q);              // on first vertex
    q[9] = fx(1); send_query(q);                             // on second vertex
    q[9] = 32'h0000_8000; q[10] = 32'h0000_8000; send_query(q); // on the far edge
    q[9] = fx(-3); q[10] = fx(5); q[11] = fx(7); send_query(q); // outside, off plane
    q[9] = 32'h0000_5555; q[10] = 32'h0000_5555; q[11] = '0; send_query(q); // rounding
    // degenerate: all vertices equal, then collinear
    q = '{default: fx(2)};
    send_query(q);
    q = '{fx(0), fx(0), fx(0), fx(1), fx(1), fx(1), fx(2), fx(2), fx(2),
          fx(1), fx(0), fx(0)};
    send_query(q);
    // extremes of the coordinate range
    q = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_query(q);
    q = '{default: 32'hffff_ffff}; q[3] = '0; q[7] = '0; send_query(q);
    // tiny triangle with a far point: weights saturate
    q = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'h7fff_ffff, 32'h8000_0000, 0};
    send_query(q);
    q[9] = 32'h8000_0000; q[10] = 32'h7fff_ffff; send_query(q);
    q[9] = 32'h0000_1000; q[10] = 32'hffff_f000; send_query(q);

    // Random queries in three regimes: light idling, heavy idling, none.
    for (int i = 0; i < N_RANDOM; i++) begin
      pct = (i < 450) ? 29 : (i < 900) ? 72 : 0;
      if (i == 450 || i == 1100) begin
        // hold off until the pipeline has drained completely
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      if (pct != 0) idle_gap(pct);
      random_query(q);
      send_query(q);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d queries: %0d degenerate, %0d saturated, %0d outside the triangle.",
             n_sent, n_degen, n_sat, n_outside);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ptb_pkg.sv
hdl/ptb_mul.sv
hdl/ptb_div.sv
hdl/point_triangle_barycentric.sv
hdl/ptb_checker.sv
sim/ptb_checker.sv
sim/tb_point_triangle_barycentric.sv
